/* rtl/osm_pkg.sv */
package osm_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_QUERY  = 3'd2,
    KIND_SELECT = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCMP,
    ST_INS_RD,
    ST_INS_WR,
    ST_ERA_RD,
    ST_ERA_WR,
    ST_SEL_WAIT,
    ST_DONE
  } state_e;

  localparam int unsigned KindW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned RankW  = 6;
  localparam int unsigned OutW   = 7;
  localparam int unsigned StatW  = 2;

endpackage

/* rtl/osm_req_if.sv */
interface osm_req_if;
  logic                                valid;
  logic                                ready;
  logic [osm_pkg::KindW-1:0]           kind;
  logic signed [osm_pkg::ValueW-1:0]   operand_value;
  logic [osm_pkg::RankW-1:0]           rank_wanted;

  modport source (output valid, kind, operand_value, rank_wanted, input ready);
  modport sink   (input valid, kind, operand_value, rank_wanted, output ready);
endinterface

/* rtl/osm_rsp_if.sv */
interface osm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                present;
  logic signed [osm_pkg::OutW-1:0]     first_rank;
  logic signed [osm_pkg::OutW-1:0]     last_rank;
  logic [osm_pkg::OutW-1:0]            occurrences;
  logic signed [osm_pkg::ValueW-1:0]   selected_value;
  logic [osm_pkg::OutW-1:0]            element_count;
  logic [osm_pkg::StatW-1:0]           status;

  modport source (output valid, present, first_rank, last_rank, occurrences,
                  selected_value, element_count, status, input ready);
  modport sink   (input valid, present, first_rank, last_rank, occurrences,
                  selected_value, element_count, status, output ready);
endinterface

/* rtl/order_statistic_multiset.sv */
// Channel  Dir  Modport      Payload
// req_i    in   sink         kind, operand_value, rank_wanted
// rsp_o    out  source       present, first/last_rank, occurrences, selected_value,
//                            element_count, status
//
// Clear, unused kinds and an insert into a full store go straight to the response;
// select reads one store entry first. Query and erase run two binary searches
// (insert runs only the upper one), each probe a store read and then a compare;
// insert and erase then move entries one at a time (read, write back). Reset
// clears the fill level, state and response valid; store contents are left as
// they are. A new request is taken while the previous response still waits on
// rsp_o; the one after it stalls until that response is taken.
module order_statistic_multiset #(
  parameter int unsigned CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  osm_req_if.sink    req_i,
  osm_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = CW + osm_pkg::RankW;
  localparam int unsigned OW = osm_pkg::OutW;

  osm_pkg::state_e state_q, state_d;

  logic [osm_pkg::KindW-1:0]         kind_q, kind_d;
  logic signed [osm_pkg::ValueW-1:0] val_q, val_d;
  logic [CW-1:0]                     fill_q, fill_d;
  logic [CW-1:0]                     lo_q, lo_d;
  logic [CW-1:0]                     hi_q, hi_d;
  logic [CW-1:0]                     mid_q, mid_d;
  logic [CW-1:0]                     pos_q, pos_d;
  logic [CW-1:0]                     upp_q, upp_d;
  logic [CW-1:0]                     sh_q, sh_d;
  logic                              upper_q, upper_d;
  logic [osm_pkg::StatW-1:0]         stat_q, stat_d;
  logic signed [osm_pkg::ValueW-1:0] sel_q, sel_d;

  logic                              out_valid_q, out_valid_d;
  logic                              out_present_q, out_present_d;
  logic signed [OW-1:0]              out_first_q, out_first_d;
  logic signed [OW-1:0]              out_last_q, out_last_d;
  logic [OW-1:0]                     out_occ_q, out_occ_d;
  logic signed [osm_pkg::ValueW-1:0] out_sel_q, out_sel_d;
  logic [OW-1:0]                     out_count_q, out_count_d;
  logic [osm_pkg::StatW-1:0]         out_stat_q, out_stat_d;

  logic signed [osm_pkg::ValueW-1:0] store_mem [CAPACITY];
  logic signed [osm_pkg::ValueW-1:0] rd_data_q;
  logic                              mem_re, mem_we;
  logic [AW-1:0]                     mem_ra, mem_wa;
  logic signed [osm_pkg::ValueW-1:0] mem_wd;

  logic [CW:0]                       mid_sum;
  logic [RW-1:0]                     rank_ext;
  logic [CW-1:0]                     sh_next;
  logic [CW-1:0]                     sh_prev;
  logic                              probe_below;
  logic                              found;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[mem_ra];
    end
  end

  always_comb begin
    mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
    rank_ext    = RW'(req_i.rank_wanted);
    sh_next     = sh_q + CW'(1);
    sh_prev     = sh_q - CW'(1);
    probe_below = upper_q ? (rd_data_q <= val_q) : (rd_data_q < val_q);
    found       = upp_q > pos_q;
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    val_d   = val_q;
    fill_d  = fill_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    upp_d   = upp_q;
    sh_d    = sh_q;
    upper_d = upper_q;
    stat_d  = stat_q;
    sel_d   = sel_q;

    out_valid_d   = out_valid_q & ~rsp_o.ready;
    out_present_d = out_present_q;
    out_first_d   = out_first_q;
    out_last_d    = out_last_q;
    out_occ_d     = out_occ_q;
    out_sel_d     = out_sel_q;
    out_count_d   = out_count_q;
    out_stat_d    = out_stat_q;

    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_ra = mid_q[AW-1:0];
    mem_wa = sh_q[AW-1:0];
    mem_wd = rd_data_q;

    req_i.ready = (state_q == osm_pkg::ST_IDLE);

    unique case (state_q)
      osm_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          val_d   = req_i.operand_value;
          stat_d  = osm_pkg::STAT_OK;
          sel_d   = '0;
          lo_d    = '0;
          hi_d    = fill_q;
          pos_d   = '0;
          upp_d   = '0;
          upper_d = 1'b0;
          state_d = osm_pkg::ST_DONE;
          unique case (req_i.kind)
            osm_pkg::KIND_INSERT: begin
              if (fill_q >= CW'(CAPACITY)) begin
                stat_d = osm_pkg::STAT_FULL;
              end else begin
                upper_d = 1'b1;
                state_d = osm_pkg::ST_SEARCH;
              end
            end
            osm_pkg::KIND_ERASE, osm_pkg::KIND_QUERY: begin
              state_d = osm_pkg::ST_SEARCH;
            end
            osm_pkg::KIND_SELECT: begin
              if (rank_ext < RW'(fill_q)) begin
                mem_re  = 1'b1;
                mem_ra  = rank_ext[AW-1:0];
                state_d = osm_pkg::ST_SEL_WAIT;
              end else begin
                stat_d = osm_pkg::STAT_RANGE;
              end
            end
            osm_pkg::KIND_CLEAR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      osm_pkg::ST_SEARCH: begin
        if (lo_q == hi_q) begin
          if (!upper_q) begin
            // lower bound found; upper bound search starts from it
            pos_d   = lo_q;
            upper_d = 1'b1;
            hi_d    = fill_q;
          end else begin
            upp_d = lo_q;
            priority if (kind_q == osm_pkg::KIND_INSERT) begin
              pos_d   = lo_q;
              sh_d    = fill_q;
              state_d = osm_pkg::ST_INS_RD;
            end else if (kind_q == osm_pkg::KIND_ERASE) begin
              if (lo_q > pos_q) begin
                sh_d    = pos_q;
                state_d = osm_pkg::ST_ERA_RD;
              end else begin
                stat_d  = osm_pkg::STAT_ABSENT;
                state_d = osm_pkg::ST_DONE;
              end
            end else begin
              state_d = osm_pkg::ST_DONE;
            end
          end
        end else begin
          mid_d   = mid_sum[CW:1];
          mem_re  = 1'b1;
          mem_ra  = mid_sum[AW:1];
          state_d = osm_pkg::ST_SCMP;
        end
      end

      osm_pkg::ST_SCMP: begin
        if (probe_below) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = osm_pkg::ST_SEARCH;
      end

      osm_pkg::ST_INS_RD: begin
        if (sh_q == pos_q) begin
          mem_we  = 1'b1;
          mem_wa  = pos_q[AW-1:0];
          mem_wd  = val_q;
          fill_d  = fill_q + CW'(1);
          state_d = osm_pkg::ST_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = sh_prev[AW-1:0];
          state_d = osm_pkg::ST_INS_WR;
        end
      end

      osm_pkg::ST_INS_WR: begin
        // move one entry up, working from the top down
        mem_we  = 1'b1;
        sh_d    = sh_prev;
        state_d = osm_pkg::ST_INS_RD;
      end

      osm_pkg::ST_ERA_RD: begin
        if (sh_next == fill_q) begin
          fill_d  = fill_q - CW'(1);
          state_d = osm_pkg::ST_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = sh_next[AW-1:0];
          state_d = osm_pkg::ST_ERA_WR;
        end
      end

      osm_pkg::ST_ERA_WR: begin
        // move one entry down over the erased slot
        mem_we  = 1'b1;
        sh_d    = sh_next;
        state_d = osm_pkg::ST_ERA_RD;
      end

      osm_pkg::ST_SEL_WAIT: begin
        sel_d   = rd_data_q;
        state_d = osm_pkg::ST_DONE;
      end

      osm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_present_d = 1'b0;
          out_first_d   = '1;
          out_last_d    = '1;
          out_occ_d     = '0;
          if (kind_q == osm_pkg::KIND_QUERY && found) begin
            out_present_d = 1'b1;
            out_first_d   = OW'(pos_q);
            out_last_d    = OW'(upp_q - CW'(1));
            out_occ_d     = OW'(upp_q - pos_q);
          end
          if (kind_q == osm_pkg::KIND_ERASE && stat_q == osm_pkg::STAT_OK) begin
            out_present_d = 1'b1;
          end
          out_sel_d   = sel_q;
          out_count_d = OW'(fill_q);
          out_stat_d  = stat_q;
          state_d     = osm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = osm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= osm_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    val_q         <= val_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    pos_q         <= pos_d;
    upp_q         <= upp_d;
    sh_q          <= sh_d;
    upper_q       <= upper_d;
    stat_q        <= stat_d;
    sel_q         <= sel_d;
    out_present_q <= out_present_d;
    out_first_q   <= out_first_d;
    out_last_q    <= out_last_d;
    out_occ_q     <= out_occ_d;
    out_sel_q     <= out_sel_d;
    out_count_q   <= out_count_d;
    out_stat_q    <= out_stat_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.present        = out_present_q;
  assign rsp_o.first_rank     = out_first_q;
  assign rsp_o.last_rank      = out_last_q;
  assign rsp_o.occurrences    = out_occ_q;
  assign rsp_o.selected_value = out_sel_q;
  assign rsp_o.element_count  = out_count_q;
  assign rsp_o.status         = out_stat_q;

endmodule

/* rtl/osm_checker.sv */
module osm_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              present_i,
  input logic signed [osm_pkg::OutW-1:0]   first_rank_i,
  input logic signed [osm_pkg::OutW-1:0]   last_rank_i,
  input logic [osm_pkg::OutW-1:0]          occurrences_i,
  input logic signed [osm_pkg::ValueW-1:0] selected_value_i,
  input logic [osm_pkg::OutW-1:0]          element_count_i,
  input logic [osm_pkg::StatW-1:0]         status_i
);

  localparam int unsigned OW = osm_pkg::OutW;

  // full refusal only when the store really is at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == osm_pkg::STAT_FULL)
      |-> (element_count_i == OW'(CAPACITY)))
    else $error("full insert refusal with store not at capacity");

  // a failed select returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == osm_pkg::STAT_RANGE) |-> (selected_value_i == '0))
    else $error("out-of-range select returned a value");

  // rank span and occurrence count agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && present_i && occurrences_i != '0)
      |-> (OW'(last_rank_i - first_rank_i + OW'(1)) == occurrences_i))
    else $error("rank span disagrees with occurrences");

  // erase absent never reports presence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == osm_pkg::STAT_ABSENT) |-> !present_i)
    else $error("absent erase reports present");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i)
      |=> (rsp_valid_i && $stable(element_count_i) && $stable(status_i)))
    else $error("stalled response changed");

endmodule

bind order_statistic_multiset osm_checker #(.CAPACITY(CAPACITY)) u_osm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .present_i        (rsp_o.present),
  .first_rank_i     (rsp_o.first_rank),
  .last_rank_i      (rsp_o.last_rank),
  .occurrences_i    (rsp_o.occurrences),
  .selected_value_i (rsp_o.selected_value),
  .element_count_i  (rsp_o.element_count),
  .status_i         (rsp_o.status)
);
